// File: rtl/rat_pkg.sv
// rat_pkg: widths, word types and control structs for the register alias table
// no dependencies; imported by the interfaces and all rtl modules

package rat_pkg;

    localparam int NUM_REGS   = 32;
    localparam int DATA_WIDTH = 32;
    localparam int TAG_WIDTH  = 8;
    localparam int REG_WIDTH  = 5;

    typedef enum logic {
        OP_ISSUE = 1'b0,
        OP_BCAST = 1'b1
    } t_op;

    typedef logic [DATA_WIDTH-1:0] t_data;
    typedef logic [TAG_WIDTH-1:0]  t_tag;
    typedef logic [REG_WIDTH-1:0]  t_regnum;

    localparam t_tag TAG_READY = '0;

    // input word as held in the input register
    typedef struct packed {
        t_op     op;
        logic    src1_use;
        t_regnum src1_reg;
        logic    src2_use;
        t_regnum src2_reg;
        logic    dest_use;
        t_regnum dest_reg;
        t_tag    tag;
        t_data   bus_value;
    } t_in_word;

    // result word as held in the output register
    typedef struct packed {
        t_tag  src1_tag;
        t_data src1_value;
        t_tag  src2_tag;
        t_data src2_value;
    } t_out_word;

    // common data bus broadcast seen by every cell
    typedef struct packed {
        logic  en;
        t_tag  tag;
        t_data value;
    } t_bcast;

    // per-cell rename write at issue
    typedef struct packed {
        logic en;
        t_tag tag;
    } t_rename;

endpackage

// File: rtl/rat_in_if.sv
// rat_in_if: valid/ready channel carrying issue and broadcast words
// depends on rat_pkg

interface rat_in_if;
    import rat_pkg::*;

    logic    valid;
    logic    ready;
    logic    op;
    logic    src1_use;
    t_regnum src1_reg;
    logic    src2_use;
    t_regnum src2_reg;
    logic    dest_use;
    t_regnum dest_reg;
    t_tag    tag;
    t_data   bus_value;

    modport source (
        output valid, op, src1_use, src1_reg, src2_use, src2_reg,
               dest_use, dest_reg, tag, bus_value,
        input  ready
    );

    modport sink (
        input  valid, op, src1_use, src1_reg, src2_use, src2_reg,
               dest_use, dest_reg, tag, bus_value,
        output ready
    );
endinterface

// File: rtl/rat_out_if.sv
// rat_out_if: valid/ready channel carrying source operand result words
// depends on rat_pkg

interface rat_out_if;
    import rat_pkg::*;

    logic  valid;
    logic  ready;
    t_tag  src1_tag;
    t_data src1_value;
    t_tag  src2_tag;
    t_data src2_value;

    modport source (
        output valid, src1_tag, src1_value, src2_tag, src2_value,
        input  ready
    );

    modport sink (
        input  valid, src1_tag, src1_value, src2_tag, src2_value,
        output ready
    );
endinterface

// File: rtl/rat_cell.sv
// rat_cell: one architectural register with its producer tag and bus snoop
// depends on rat_pkg

module rat_cell (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rat_pkg::t_bcast  i_bcast,
    input  rat_pkg::t_rename i_rename,
    output rat_pkg::t_tag    o_tag,
    output rat_pkg::t_data   o_value
);
    import rat_pkg::*;

    t_tag  r_tag,   n_tag;
    t_data r_value, n_value;

    always_comb begin
        n_tag   = r_tag;
        n_value = r_value;
        // broadcast and rename never arrive together
        if (i_bcast.en && (r_tag == i_bcast.tag)) begin
            n_tag   = TAG_READY;
            n_value = i_bcast.value;
        end else if (i_rename.en) begin
            n_tag = i_rename.tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag   <= TAG_READY;
            r_value <= '0;
        end else begin
            r_tag   <= n_tag;
            r_value <= n_value;
        end
    end

    assign o_tag   = r_tag;
    assign o_value = r_value;
endmodule

// File: rtl/rat_read_port.sv
// rat_read_port: selects tag and value of one source register from the cell row
// depends on rat_pkg

module rat_read_port (
    input  logic            i_use,
    input  rat_pkg::t_regnum i_reg,
    input  rat_pkg::t_tag    i_tags   [rat_pkg::NUM_REGS],
    input  rat_pkg::t_data   i_values [rat_pkg::NUM_REGS],
    output rat_pkg::t_tag    o_tag,
    output rat_pkg::t_data   o_value
);
    import rat_pkg::*;

    // unused source or number past the file reads as zero
    always_comb begin
        o_tag   = TAG_READY;
        o_value = '0;
        for (int i = 0; i < NUM_REGS; i++) begin
            if (i_use && (int'(i_reg) == i)) begin
                o_tag   = i_tags[i];
                o_value = i_values[i];
            end
        end
    end
endmodule

// File: rtl/tomasulo_register_alias_table.sv
// tomasulo_register_alias_table: register file with producer tags for issue
// depends on rat_pkg, rat_in_if, rat_out_if, rat_cell, rat_read_port
//
//  channel | dir | words carried
//  --------+-----+-----------------------------------------------------------
//  i_in    | in  | op, src1/src2 use+reg, dest use+reg, tag, bus_value
//  o_out   | out | src1_tag, src1_value, src2_tag, src2_value (one per input)
//
// one word a cycle while the output is not stalled: an accepted word sits in
// the input register, where it reads the cell row; when it advances it updates
// the row and lands in the output register
// the row of cells updates at the same edge as the result is registered, so
// the following word already sees the new tags and values
// synchronous reset clears all tags and values (every register ready)
// a stalled output holds the input register; i_in.ready is high while that register is empty or its word advances

module tomasulo_register_alias_table (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rat_in_if.sink    i_in,
    rat_out_if.source o_out
);
    import rat_pkg::*;

    // input register
    logic     r_in_valid;
    t_in_word r_in;

    // output register
    logic      r_out_valid;
    t_out_word r_out;
    t_out_word n_out;

    // advance the held word into the output register
    logic advance;
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.op        <= t_op'(i_in.op);
            r_in.src1_use  <= i_in.src1_use;
            r_in.src1_reg  <= i_in.src1_reg;
            r_in.src2_use  <= i_in.src2_use;
            r_in.src2_reg  <= i_in.src2_reg;
            r_in.dest_use  <= i_in.dest_use;
            r_in.dest_reg  <= i_in.dest_reg;
            r_in.tag       <= i_in.tag;
            r_in.bus_value <= i_in.bus_value;
        end
    end

    // cell row controls, only while the word actually moves on
    logic   is_issue;
    t_bcast bcast;
    assign is_issue    = (r_in.op == OP_ISSUE);
    assign bcast.en    = advance && !is_issue && (r_in.tag != TAG_READY);
    assign bcast.tag   = r_in.tag;
    assign bcast.value = r_in.bus_value;

    t_tag  cell_tags   [NUM_REGS];
    t_data cell_values [NUM_REGS];

    for (genvar g = 0; g < NUM_REGS; g++) begin : g_cell
        t_rename rename;
        // rename takes effect after the sources read the old tag
        assign rename.en  = advance && is_issue && r_in.dest_use
                            && (int'(r_in.dest_reg) == g);
        assign rename.tag = r_in.tag;

        rat_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_bcast  (bcast),
            .i_rename (rename),
            .o_tag    (cell_tags[g]),
            .o_value  (cell_values[g])
        );
    end

    // source reads; a broadcast reports all zero
    t_tag  rd1_tag,   rd2_tag;
    t_data rd1_value, rd2_value;

    rat_read_port u_rd1 (
        .i_use    (is_issue && r_in.src1_use),
        .i_reg    (r_in.src1_reg),
        .i_tags   (cell_tags),
        .i_values (cell_values),
        .o_tag    (rd1_tag),
        .o_value  (rd1_value)
    );

    rat_read_port u_rd2 (
        .i_use    (is_issue && r_in.src2_use),
        .i_reg    (r_in.src2_reg),
        .i_tags   (cell_tags),
        .i_values (cell_values),
        .o_tag    (rd2_tag),
        .o_value  (rd2_value)
    );

    always_comb begin
        n_out.src1_tag   = rd1_tag;
        n_out.src1_value = rd1_value;
        n_out.src2_tag   = rd2_tag;
        n_out.src2_value = rd2_value;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.src1_tag   = r_out.src1_tag;
    assign o_out.src1_value = r_out.src1_value;
    assign o_out.src2_tag   = r_out.src2_tag;
    assign o_out.src2_value = r_out.src2_value;
endmodule
